@@ hw/rtl/deadline_ordered_timer_queue_macros.svh @@
// Assertion macros for the deadline ordered timer queue.
// Included by modules that carry concurrent assertions.
`ifndef DEADLINE_ORDERED_TIMER_QUEUE_MACROS_SVH
`define DEADLINE_ORDERED_TIMER_QUEUE_MACROS_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define DOTQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define DOTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/dotq_pkg.sv @@
// Package for the deadline ordered timer queue.
// Holds sizes, codes and the cell command and status structs; no dependencies.
`timescale 1ns / 1ps

package dotq_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int TASK_ID_BITS = 8;
    localparam int CNT_BITS     = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_BITS     = $clog2(QUEUE_DEPTH);
    localparam logic [9:0] MS_PER_SEC = 10'd1000;
    localparam logic [9:0] MS_MAX     = 10'd999;

    typedef enum logic [2:0] {
        ACT_SCHEDULE = 3'd0,
        ACT_EXPIRE   = 3'd1,
        ACT_CANCEL   = 3'd2,
        ACT_ADJUST   = 3'd3,
        ACT_FLUSH    = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        EV_ACCEPTED = 3'd0,
        EV_FIRED    = 3'd1,
        EV_DEACT    = 3'd2,
        EV_FULL     = 3'd3,
        EV_DUP      = 3'd4,
        EV_NOTFOUND = 3'd5,
        EV_IDLE     = 3'd6
    } event_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_APPLY,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // insert: entries at or after the insert point move one cell up.
    // remove: entries above the remove point move one cell down.
    typedef struct packed {
        logic                    insert;
        logic                    remove;
        logic                    adjust;
        logic [TASK_ID_BITS-1:0] new_task;
        logic [31:0]             new_sec;
        logic [9:0]              new_ms;
        logic [31:0]             now_sec;
        logic [9:0]              now_ms;
        logic [31:0]             offset;
        logic [TASK_ID_BITS-1:0] match_task;
    } cell_cmd_t;

    typedef struct packed {
        logic                    before_new;
        logic                    due;
        logic                    match;
        logic [TASK_ID_BITS-1:0] task_id;
    } cell_stat_t;

endpackage

@@ hw/rtl/deadline_ordered_timer_queue.sv @@
// Deadline ordered timer queue: sequencer around a chain of sorted cells.
// A single result is registered in the check state once the result register is free;
// expire and flush with entries register their results from the drain state, one per cycle
// while the result register is not stalled. A new request is taken only when the sequencer
// is idle, so each request is finished before the next one is taken.
// Reset: rst_n asynchronous, active low, empties the queue; cell data undefined.
`timescale 1ns / 1ps
`include "deadline_ordered_timer_queue_macros.svh"

module deadline_ordered_timer_queue
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [7:0]  task_id,
    input  logic [31:0] wait_seconds,
    input  logic [9:0]  delay_millis,
    input  logic [31:0] now_seconds,
    input  logic [9:0]  now_millis,
    input  logic [31:0] offset_seconds,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  result_task,
    output logic [2:0]  event_kind,
    output logic        still_busy,
    output logic        last_result
);

    localparam int D  = dotq_pkg::QUEUE_DEPTH;
    localparam int TB = dotq_pkg::TASK_ID_BITS;
    localparam int CB = dotq_pkg::CNT_BITS;

    dotq_pkg::state_t state_reg, state_next;

    logic [2:0]  act_reg;
    logic [TB-1:0] id_reg;
    logic [31:0] sec_reg;
    logic [9:0]  ms_reg;
    logic [31:0] nsec_reg;
    logic [9:0]  nms_reg;
    logic [31:0] off_reg;
    logic [CB-1:0] count_reg, count_next;
    logic        fired_reg, fired_next;

    logic        ov_reg;
    logic [7:0]  rt_reg;
    logic [2:0]  ek_reg;
    logic        last_reg;
    logic        busy_reg;

    dotq_pkg::cell_cmd_t  cmd;
    dotq_pkg::cell_stat_t stat [D];
    logic [TB-1:0] ctask [D];
    logic [31:0]   csec [D];
    logic [9:0]    cms [D];
    logic          cgone [D];
    logic          cbefore [D];
    logic [D-1:0]  occ, match_v;

    logic          accept, out_free, any_match, head_due;
    logic [9:0]    dms_c, nms_c;
    logic [10:0]   msum;
    logic [31:0]   new_sec;
    logic [9:0]    new_ms;

    assign accept   = in_valid && !in_stall;
    assign out_free = !ov_reg || !out_stall;
    assign in_stall = (state_reg != dotq_pkg::ST_IDLE);

    assign dms_c = (delay_millis > dotq_pkg::MS_MAX) ? dotq_pkg::MS_MAX : delay_millis;
    assign nms_c = (now_millis > dotq_pkg::MS_MAX) ? dotq_pkg::MS_MAX : now_millis;
    assign msum  = {1'b0, dms_c} + {1'b0, nms_c};

    always_comb
    begin
        if (msum >= {1'b0, dotq_pkg::MS_PER_SEC})
        begin
            new_ms  = 10'(msum - {1'b0, dotq_pkg::MS_PER_SEC});
            new_sec = wait_seconds + now_seconds + 32'd1;
        end
        else
        begin
            new_ms  = msum[9:0];
            new_sec = wait_seconds + now_seconds;
        end
    end

    for (genvar g = 0; g < D; g++)
    begin : g_cells
        logic          lb, lg;
        logic [TB-1:0] lt, ut;
        logic [31:0]   ls, us;
        logic [9:0]    lm, um;
        assign occ[g]     = (CB'(g) < count_reg);
        assign match_v[g] = stat[g].match;
        if (g == 0)
        begin : g_lo
            assign lb = 1'b1;
            assign lg = 1'b0;
            assign lt = '0;
            assign ls = '0;
            assign lm = '0;
        end
        else
        begin : g_mid
            assign lb = cbefore[g-1];
            assign lg = cgone[g-1];
            assign lt = ctask[g-1];
            assign ls = csec[g-1];
            assign lm = cms[g-1];
        end
        if (g == D - 1)
        begin : g_hi
            assign ut = ctask[g];
            assign us = csec[g];
            assign um = cms[g];
        end
        else
        begin : g_up
            assign ut = ctask[g+1];
            assign us = csec[g+1];
            assign um = cms[g+1];
        end
        dotq_cell u_cell
        (
            .clk          (clk),
            .cmd          (cmd),
            .occupied     (occ[g]),
            .lower_before (lb),
            .lower_gone   (lg),
            .lower_task   (lt),
            .lower_sec    (ls),
            .lower_ms     (lm),
            .upper_task   (ut),
            .upper_sec    (us),
            .upper_ms     (um),
            .before_all   (cbefore[g]),
            .gone         (cgone[g]),
            .task_q       (ctask[g]),
            .sec_q        (csec[g]),
            .ms_q         (cms[g]),
            .stat         (stat[g])
        );
    end

    assign any_match = |match_v;
    assign head_due  = stat[0].due;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dotq_pkg::ST_IDLE:
                if (accept)
                    state_next = dotq_pkg::ST_CHECK;
            dotq_pkg::ST_CHECK:
                if (out_free)
                begin
                    if (act_reg == dotq_pkg::ACT_EXPIRE)
                        state_next = head_due ? dotq_pkg::ST_DRAIN : dotq_pkg::ST_EMIT;
                    else if (act_reg == dotq_pkg::ACT_FLUSH)
                        state_next = (count_reg != '0) ? dotq_pkg::ST_DRAIN
                                                       : dotq_pkg::ST_EMIT;
                    else
                        state_next = dotq_pkg::ST_EMIT;
                end
            dotq_pkg::ST_DRAIN:
                if (out_free)
                begin
                    if (act_reg == dotq_pkg::ACT_EXPIRE)
                    begin
                        if (!(count_reg > CB'(1) && stat[1].due))
                            state_next = dotq_pkg::ST_APPLY;
                    end
                    else if (count_reg <= CB'(1))
                        state_next = dotq_pkg::ST_APPLY;
                end
            dotq_pkg::ST_APPLY:
                state_next = dotq_pkg::ST_IDLE;
            dotq_pkg::ST_EMIT:
                state_next = dotq_pkg::ST_IDLE;
            default:
                state_next = dotq_pkg::ST_IDLE;
        endcase
    end

    // Outputs to the chain and counters
    always_comb
    begin
        cmd            = '0;
        cmd.new_task   = id_reg;
        cmd.new_sec    = sec_reg;
        cmd.new_ms     = ms_reg;
        cmd.now_sec    = nsec_reg;
        cmd.now_ms     = nms_reg;
        cmd.offset     = off_reg;
        cmd.match_task = id_reg;
        count_next     = count_reg;
        fired_next     = fired_reg;
        case (state_reg)
            dotq_pkg::ST_IDLE:
                fired_next = 1'b0;
            dotq_pkg::ST_CHECK:
                if (out_free)
                begin
                    case (act_reg)
                        dotq_pkg::ACT_SCHEDULE:
                            if (!any_match && count_reg < CB'(D))
                            begin
                                cmd.insert = 1'b1;
                                count_next = count_reg + CB'(1);
                            end
                        dotq_pkg::ACT_CANCEL:
                            if (any_match)
                            begin
                                cmd.remove = 1'b1;
                                count_next = count_reg - CB'(1);
                            end
                        dotq_pkg::ACT_ADJUST:
                            cmd.adjust = 1'b1;
                        default:
                            ;
                    endcase
                end
            dotq_pkg::ST_DRAIN:
                if (out_free)
                begin
                    cmd.remove     = 1'b1;
                    cmd.match_task = ctask[0];
                    count_next     = count_reg - CB'(1);
                    if (act_reg == dotq_pkg::ACT_EXPIRE)
                        fired_next = 1'b1;
                end
            default:
                ;
        endcase
    end

    // State, counter and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dotq_pkg::ST_IDLE;
            count_reg <= '0;
            fired_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            fired_reg <= fired_next;
            if (out_free && (state_reg == dotq_pkg::ST_DRAIN ||
                (state_reg == dotq_pkg::ST_CHECK && state_next == dotq_pkg::ST_EMIT)))
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= action;
            id_reg   <= task_id[TB-1:0];
            sec_reg  <= new_sec;
            ms_reg   <= new_ms;
            nsec_reg <= now_seconds;
            nms_reg  <= nms_c;
            off_reg  <= offset_seconds;
        end
        if (out_free && state_reg == dotq_pkg::ST_CHECK)
        begin
            last_reg <= 1'b1;
            case (act_reg)
                dotq_pkg::ACT_SCHEDULE:
                begin
                    rt_reg <= 8'(id_reg);
                    if (any_match)
                        ek_reg <= dotq_pkg::EV_DUP;
                    else if (count_reg >= CB'(D))
                        ek_reg <= dotq_pkg::EV_FULL;
                    else
                        ek_reg <= dotq_pkg::EV_ACCEPTED;
                    busy_reg <= 1'b1;
                end
                dotq_pkg::ACT_CANCEL:
                begin
                    rt_reg   <= 8'(id_reg);
                    ek_reg   <= any_match ? dotq_pkg::EV_DEACT : dotq_pkg::EV_NOTFOUND;
                    busy_reg <= (count_reg > CB'(1)) || (!any_match && count_reg != '0);
                end
                dotq_pkg::ACT_ADJUST:
                begin
                    rt_reg   <= '0;
                    ek_reg   <= dotq_pkg::EV_ACCEPTED;
                    busy_reg <= (count_reg != '0);
                end
                default:
                begin
                    rt_reg   <= '0;
                    ek_reg   <= dotq_pkg::EV_IDLE;
                    busy_reg <= (count_reg != '0);
                end
            endcase
        end
        else if (out_free && state_reg == dotq_pkg::ST_DRAIN)
        begin
            rt_reg <= 8'(ctask[0]);
            if (act_reg == dotq_pkg::ACT_EXPIRE)
            begin
                ek_reg   <= dotq_pkg::EV_FIRED;
                busy_reg <= 1'b1;
                last_reg <= !(count_reg > CB'(1) && stat[1].due);
            end
            else
            begin
                ek_reg   <= dotq_pkg::EV_DEACT;
                busy_reg <= 1'b0;
                last_reg <= (count_reg <= CB'(1));
            end
        end
    end

    assign out_valid   = ov_reg;
    assign result_task = rt_reg;
    assign event_kind  = ek_reg;
    assign still_busy  = busy_reg;
    assign last_result = last_reg;

    `DOTQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CB'(D), "count over depth")
    `DOTQ_ASSERT_IMP(a_stall_busy, clk, rst_n, state_reg != dotq_pkg::ST_IDLE, in_stall,
        "input taken while busy")
    `DOTQ_ASSERT_NEXT(a_apply_idle, clk, rst_n, state_reg == dotq_pkg::ST_APPLY,
        state_reg == dotq_pkg::ST_IDLE, "apply did not return to idle")
    `DOTQ_ASSERT_IMP(a_drain_nonempty, clk, rst_n, state_reg == dotq_pkg::ST_DRAIN,
        count_reg != '0, "drain on empty queue")

endmodule

@@ hw/rtl/dotq_cell.sv @@
// One queue cell: holds a task and deadline, compares it, shifts with neighbors and adds the adjust offset.
// Depends on dotq_pkg.
`timescale 1ns / 1ps

module dotq_cell
(
    input  logic                             clk,
    input  dotq_pkg::cell_cmd_t              cmd,
    input  logic                             occupied,
    input  logic                             lower_before,
    input  logic                             lower_gone,
    input  logic [dotq_pkg::TASK_ID_BITS-1:0] lower_task,
    input  logic [31:0]                      lower_sec,
    input  logic [9:0]                       lower_ms,
    input  logic [dotq_pkg::TASK_ID_BITS-1:0] upper_task,
    input  logic [31:0]                      upper_sec,
    input  logic [9:0]                       upper_ms,
    output logic                             before_all,
    output logic                             gone,
    output logic [dotq_pkg::TASK_ID_BITS-1:0] task_q,
    output logic [31:0]                      sec_q,
    output logic [9:0]                       ms_q,
    output dotq_pkg::cell_stat_t             stat
);

    logic [dotq_pkg::TASK_ID_BITS-1:0] task_reg;
    logic [31:0]                       sec_reg;
    logic [9:0]                        ms_reg;

    always_comb
    begin
        stat.before_new = occupied && ((sec_reg < cmd.new_sec) ||
                          ((sec_reg == cmd.new_sec) && (ms_reg < cmd.new_ms)));
        stat.due        = occupied && ((sec_reg < cmd.now_sec) ||
                          ((sec_reg == cmd.now_sec) && (ms_reg <= cmd.now_ms)));
        stat.match      = occupied && (task_reg == cmd.match_task);
        stat.task_id    = task_reg;
        before_all      = lower_before && stat.before_new;
        gone            = lower_gone || stat.match;
    end

    assign task_q = task_reg;
    assign sec_q  = sec_reg;
    assign ms_q   = ms_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.insert && !before_all)
        begin
            if (lower_before)
            begin
                task_reg <= cmd.new_task;
                sec_reg  <= cmd.new_sec;
                ms_reg   <= cmd.new_ms;
            end
            else
            begin
                task_reg <= lower_task;
                sec_reg  <= lower_sec;
                ms_reg   <= lower_ms;
            end
        end
        else if (cmd.remove && gone)
        begin
            task_reg <= upper_task;
            sec_reg  <= upper_sec;
            ms_reg   <= upper_ms;
        end
        else if (cmd.adjust)
        begin
            sec_reg <= sec_reg + cmd.offset;
        end
    end

endmodule
